@@ sv/dual_led_breathing_and_buzzer_timer_core_assert.svh @@
// Assertion macros for the dual LED breathing and buzzer timer core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DUAL_LED_BREATHING_AND_BUZZER_TIMER_CORE_ASSERT_SVH
`define DUAL_LED_BREATHING_AND_BUZZER_TIMER_CORE_ASSERT_SVH

`define DLBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DLBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dlbt_pkg.sv @@
// Package for the dual LED breathing and buzzer timer core.
// Holds the item types, the channel state type and the gamma and tick functions.
package dlbt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BUZZ  = 2'd1,
    CMD_PWR   = 2'd2,
    CMD_ST    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] duration;
    logic [15:0] speed;
    logic [15:0] count;
    logic [15:0] pause_steps;
  } in_item_t;

  typedef struct packed {
    logic [7:0] power_duty;
    logic [7:0] status_duty;
    logic       buzzer_on;
    logic       power_active;
    logic       status_active;
  } out_item_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] sweeps_left;
    logic [15:0] pause;
    logic [15:0] prescale;
    logic [16:0] level;
    logic [7:0]  duty;
  } chan_t;

  localparam logic [16:0] LEVEL_DARK = 17'd64;

  function automatic logic [7:0] gamma(input logic [4:0] idx);
    logic [7:0] g;
    case (idx)
      5'd0:  g = 8'd0;
      5'd1:  g = 8'd1;
      5'd2:  g = 8'd2;
      5'd3:  g = 8'd3;
      5'd4:  g = 8'd4;
      5'd5:  g = 8'd5;
      5'd6:  g = 8'd7;
      5'd7:  g = 8'd9;
      5'd8:  g = 8'd12;
      5'd9:  g = 8'd15;
      5'd10: g = 8'd18;
      5'd11: g = 8'd22;
      5'd12: g = 8'd27;
      5'd13: g = 8'd32;
      5'd14: g = 8'd38;
      5'd15: g = 8'd44;
      5'd16: g = 8'd51;
      5'd17: g = 8'd58;
      5'd18: g = 8'd67;
      5'd19: g = 8'd76;
      5'd20: g = 8'd86;
      5'd21: g = 8'd96;
      5'd22: g = 8'd108;
      5'd23: g = 8'd120;
      5'd24: g = 8'd134;
      5'd25: g = 8'd148;
      5'd26: g = 8'd163;
      5'd27: g = 8'd180;
      5'd28: g = 8'd197;
      5'd29: g = 8'd216;
      5'd30: g = 8'd235;
      default: g = 8'd255;
    endcase
    return g;
  endfunction

  function automatic chan_t chan_tick(input chan_t c);
    chan_t       n;
    logic [16:0] lvl;
    logic [16:0] lim;
    logic [4:0]  idx;
    n   = c;
    lvl = c.level + 17'd1;
    lim = LEVEL_DARK + {1'b0, c.pause};
    if (c.period == 16'd0) begin
      n.prescale = 16'd0;
      n.level    = 17'd0;
    end else if (({1'b0, c.prescale} + 17'd1) < {1'b0, c.period}) begin
      n.prescale = c.prescale + 16'd1;
    end else begin
      n.prescale = 16'd0;
      n.level    = lvl;
      if (lvl >= lim) begin
        n.level       = 17'd0;
        n.sweeps_left = c.sweeps_left - 16'd1;
        if (n.sweeps_left == 16'd0) begin
          n.period = 16'd0;
        end
      end
      if (n.level >= LEVEL_DARK) begin
        n.duty = 8'd0;
      end else begin
        // The falling half mirrors the rising half: 63 - level is ~level[4:0].
        idx    = n.level[5] ? ~n.level[4:0] : n.level[4:0];
        n.duty = gamma(idx);
      end
    end
    return n;
  endfunction

endpackage

@@ sv/dual_led_breathing_and_buzzer_timer_core.sv @@
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle if out_stall is low; the state update is one tick-logic pass.
// Reset (rst_n low, synchronous) turns the buzzer off, idles both LED channels and zeroes duties.
// Depends on dlbt_pkg and dual_led_breathing_and_buzzer_timer_core_assert.svh.
`include "dual_led_breathing_and_buzzer_timer_core_assert.svh"
module dual_led_breathing_and_buzzer_timer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dlbt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dlbt_pkg::out_item_t  out_item
);
  import dlbt_pkg::*;

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [31:0] buzz_rem_r,  buzz_rem_nxt;
  logic        buzz_on_r,   buzz_on_nxt;
  chan_t       pwr_r,       pwr_nxt;
  chan_t       st_r,        st_nxt;
  out_item_t   out_item_nxt;
  logic        advance;
  logic        process;

  assign advance   = !out_valid_r || !out_stall;
  assign process   = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    buzz_rem_nxt = buzz_rem_r;
    buzz_on_nxt  = buzz_on_r;
    pwr_nxt      = pwr_r;
    st_nxt       = st_r;
    case (in_item_r.cmd)
      CMD_TICK: begin
        if (buzz_rem_r != 32'd0) begin
          buzz_rem_nxt = buzz_rem_r - 32'd1;
          if (buzz_rem_nxt == 32'd0) begin
            buzz_on_nxt = 1'b0;
          end
        end
        pwr_nxt = chan_tick(pwr_r);
        st_nxt  = chan_tick(st_r);
      end
      CMD_BUZZ: begin
        buzz_rem_nxt = in_item_r.duration;
        buzz_on_nxt  = 1'b1;
      end
      CMD_PWR: begin
        pwr_nxt.period      = in_item_r.speed;
        pwr_nxt.sweeps_left = in_item_r.count;
        pwr_nxt.pause       = in_item_r.pause_steps;
      end
      default: begin
        st_nxt.period      = in_item_r.speed;
        st_nxt.sweeps_left = in_item_r.count;
        st_nxt.pause       = in_item_r.pause_steps;
      end
    endcase
    out_item_nxt.power_duty    = pwr_nxt.duty;
    out_item_nxt.status_duty   = st_nxt.duty;
    out_item_nxt.buzzer_on     = buzz_on_nxt;
    out_item_nxt.power_active  = (pwr_nxt.period != 16'd0);
    out_item_nxt.status_active = (st_nxt.period != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      buzz_rem_r  <= 32'd0;
      buzz_on_r   <= 1'b0;
      pwr_r       <= '0;
      st_r        <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (process) begin
        out_valid_r <= 1'b1;
        buzz_rem_r  <= buzz_rem_nxt;
        buzz_on_r   <= buzz_on_nxt;
        pwr_r       <= pwr_nxt;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
    if (process) begin
      out_item_r <= out_item_nxt;
    end
  end

  `DLBT_ASSERT_NOW(a_buzz_count_implies_on, buzz_rem_r != 32'd0, buzz_on_r,
    "Buzzer count is running while the buzzer is off.")
  `DLBT_ASSERT_NEXT(a_held_item_kept, in_valid_r && !advance, in_valid_r && $stable(in_item_r),
    "Held input item was lost or changed.")
  `DLBT_ASSERT_NEXT(a_idle_pwr_clears,
    process && in_item_r.cmd == CMD_TICK && pwr_r.period == 16'd0,
    pwr_r.level == 17'd0 && pwr_r.prescale == 16'd0,
    "Idle power channel did not clear on a tick.")

endmodule

@@ tb/tb_dual_led_breathing_and_buzzer_timer_core.sv @@
// Self-checking testbench for dual_led_breathing_and_buzzer_timer_core.
// A scoreboard class predicts the status after every accepted item and checks the result stream;
// it depends on dlbt_pkg and the core RTL only.
module tb_dual_led_breathing_and_buzzer_timer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dlbt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 16;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] sweeps_left;
    logic [15:0] dark_steps;
    logic [15:0] prescale;
    logic [16:0] level;
    logic [7:0]  duty;
  } lamp_t;

  class timer_tracker;
    out_item_t   status_q[$];
    int unsigned mismatches;
    logic [31:0] buzz_left;
    logic        buzz_on;
    lamp_t       pwr_lamp;
    lamp_t       st_lamp;
    logic [7:0]  gamma_lut [32];

    function new();
      gamma_lut = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9,
                    8'd12, 8'd15, 8'd18, 8'd22, 8'd27, 8'd32, 8'd38, 8'd44,
                    8'd51, 8'd58, 8'd67, 8'd76, 8'd86, 8'd96, 8'd108, 8'd120,
                    8'd134, 8'd148, 8'd163, 8'd180, 8'd197, 8'd216, 8'd235, 8'd255};
      mismatches = 0;
      buzz_left  = '0;
      buzz_on    = 1'b0;
      pwr_lamp   = '0;
      st_lamp    = '0;
    endfunction

    function lamp_t advance_lamp(lamp_t c);
      lamp_t       n;
      int unsigned lvl;
      int unsigned idx;
      n = c;
      if (c.period == 16'd0) begin
        n.prescale = '0;
        n.level    = '0;
        return n;
      end
      if (32'(c.prescale) + 32'd1 < 32'(c.period)) begin
        n.prescale = c.prescale + 16'd1;
        return n;
      end
      n.prescale = '0;
      lvl = (32'(c.level) + 32'd1) & 32'h1FFFF;
      if (lvl >= 32'd64 + 32'(c.dark_steps)) begin
        lvl           = 0;
        n.sweeps_left = c.sweeps_left - 16'd1;
        if (n.sweeps_left == 16'd0) begin
          n.period = '0;
        end
      end
      n.level = 17'(lvl);
      if (lvl >= 32'd64) begin
        n.duty = '0;
      end else begin
        idx    = (lvl < 32'd32) ? lvl : 32'd63 - lvl;
        n.duty = gamma_lut[idx];
      end
      return n;
    endfunction

    function void accept_command(in_item_t it);
      out_item_t st;
      case (it.cmd)
        CMD_TICK: begin
          if (buzz_left != 32'd0) begin
            buzz_left = buzz_left - 32'd1;
            if (buzz_left == 32'd0) begin
              buzz_on = 1'b0;
            end
          end
          pwr_lamp = advance_lamp(pwr_lamp);
          st_lamp  = advance_lamp(st_lamp);
        end
        CMD_BUZZ: begin
          buzz_left = it.duration;
          buzz_on   = 1'b1;
        end
        CMD_PWR: begin
          pwr_lamp.period      = it.speed;
          pwr_lamp.sweeps_left = it.count;
          pwr_lamp.dark_steps  = it.pause_steps;
        end
        default: begin
          st_lamp.period      = it.speed;
          st_lamp.sweeps_left = it.count;
          st_lamp.dark_steps  = it.pause_steps;
        end
      endcase
      st.power_duty    = pwr_lamp.duty;
      st.status_duty   = st_lamp.duty;
      st.buzzer_on     = buzz_on;
      st.power_active  = (pwr_lamp.period != 16'd0);
      st.status_active = (st_lamp.period != 16'd0);
      status_q.push_back(st);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected result at %0t: %p", $realtime, got);
        end
        return;
      end
      want = status_q.pop_front();
      if (got.power_duty !== want.power_duty || got.status_duty !== want.status_duty ||
          got.buzzer_on !== want.buzzer_on || got.power_active !== want.power_active ||
          got.status_active !== want.status_active) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Mismatch at %0t: expected %p, actual %p", $realtime, want, got);
        end
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  timer_tracker board = new();
  int           burst_left = 0;
  int           stall_mode = 0;
  int           stall_hold = 0;
  int           quiet_cycles = 0;

  dual_led_breathing_and_buzzer_timer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(20, 80);
    end
    stall_hold--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= stall_hold[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_status(out_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t noise_fields(cmd_t c);
    in_item_t it;
    it.cmd         = c;
    it.duration    = $urandom;
    it.speed       = 16'($urandom);
    it.count       = 16'($urandom);
    it.pause_steps = 16'($urandom);
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.accept_command(it);
  endtask

  task automatic send_cmd(cmd_t c, logic [31:0] dur, logic [15:0] spd, logic [15:0] cnt,
                          logic [15:0] pse);
    in_item_t it;
    it             = noise_fields(c);
    it.duration    = dur;
    it.speed       = spd;
    it.count       = cnt;
    it.pause_steps = pse;
    push_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    int       sent;
    int       episode;
    int       run;
    int       pick;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_BUZZ, 32'd0, '0, '0, '0);
    send_cmd(CMD_TICK, '1, '1, '1, '1);
    send_cmd(CMD_BUZZ, 32'd2, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_BUZZ, 32'hFFFF_FFFF, '1, '1, '1);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_BUZZ, 32'd1, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_PWR, '0, 16'd0, 16'd5, 16'd3);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_ST, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_PWR, '0, 16'd1, 16'd0, 16'd0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_ST, '0, 16'd1, 16'd1, 16'd0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_ST, '0, 16'd0, 16'd1, 16'd0);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    send_cmd(CMD_PWR, '0, 16'd2, 16'd1, 16'hFFFF);
    send_cmd(CMD_TICK, '0, '0, '0, '0);
    wait_drained();

    sent    = 0;
    episode = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int ch = 0; ch < 2; ch++) begin
        it = noise_fields((ch == 0) ? CMD_PWR : CMD_ST);
        if ($urandom_range(0, 9) != 0) begin
          it.speed       = 16'($urandom_range(1, 3));
          it.count       = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 2));
          it.pause_steps = 16'($urandom_range(0, 8));
        end
        push_item(it);
        sent++;
      end
      run = $urandom_range(60, 160);
      if (sent + run > RANDOM_ITEMS) begin
        run = (sent < RANDOM_ITEMS) ? RANDOM_ITEMS - sent : 0;
      end
      repeat (run) begin
        pick = $urandom_range(0, 99);
        it   = noise_fields(CMD_TICK);
        if (pick < 4) begin
          it.cmd = CMD_BUZZ;
          if ($urandom_range(0, 1) == 0) begin
            it.duration = $urandom_range(0, 30);
          end
        end else if (pick < 8) begin
          it.cmd         = ($urandom_range(0, 1) == 0) ? CMD_PWR : CMD_ST;
          it.speed       = 16'($urandom_range(0, 4));
          it.count       = 16'($urandom_range(0, 3));
          it.pause_steps = 16'($urandom_range(0, 10));
        end
        push_item(it);
        sent++;
      end
      episode++;
      if (episode == 2) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
